[hw/rtl/pcek7_pkg.sv]
// Package for the punctured K=7 convolutional encoder.
// Holds the shared queue entry and status types and the fixed constants.
// No dependencies.
package pcek7_pkg;

  localparam int unsigned POLY_W    = 7;   // tap word: input bit plus six state bits
  localparam int unsigned SHIFT_W   = 6;   // encoder shift register
  localparam int unsigned CODED_W   = 12;  // coded bits of one data byte
  localparam int unsigned TAIL_W    = 9;   // coded bits of the six-bit zero tail
  localparam int unsigned VBITS_W   = 4;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic [POLY_W-1:0] POLY_A_RESET = 7'd121;
  localparam logic [POLY_W-1:0] POLY_B_RESET = 7'd91;

  localparam logic [VBITS_W-1:0] VBITS_FULL      = 4'd8;
  localparam logic [VBITS_W-1:0] VBITS_TAIL_ODD  = 4'd5;
  localparam logic [VBITS_W-1:0] VBITS_TAIL_EVEN = 4'd1;

  localparam logic [1:0] NBYTES_TWO   = 2'd2;
  localparam logic [1:0] NBYTES_THREE = 2'd3;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_FLUSH  = 1'b1
  } op_t;

  typedef enum logic {
    CFG_POLY_A = 1'b0,
    CFG_POLY_B = 1'b1
  } cfg_idx_t;

  // One burst of result bytes, first byte in the top bits.
  typedef struct packed {
    logic [23:0]        bytes;
    logic [1:0]         n_bytes;     // 2 or 3
    logic               last;        // burst closes the message
    logic [VBITS_W-1:0] last_vbits;  // valid bits of the final byte when last is set
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[hw/rtl/punctured_conv_encoder_k7_unit.sv]
// Top level of the rate 2/3 punctured K=7 convolutional encoder.
// Depends on pcek7_pkg, pcek7_front, pcek7_queue and pcek7_back.
//
// Usage: each input word carries a message byte in in_tdata and an op code
// in in_tuser (encode or end of message). The byte is coded MSB first in bit
// pairs; every second data word releases three 8-bit result words, and an
// end-of-message word flushes six zero bits and releases two or three words,
// the last of them marked by out_tlast with 5 or 1 valid bits. out_tdata
// carries the coded byte and its count of valid bits.
// The accepting edge writes a finished burst into the queue; the output
// register is then loaded from the queue head once it is free.
// Throughput: the front end takes one word per cycle while the queue has
// room; the back end emits one result word per cycle while the receiver is
// ready, and bursts are absorbed by the QUEUE_DEPTH-entry queue. When the
// receiver stalls, the output register holds its word, the queue fills and
// in_tready falls.
// Reset clears the encoder state, the queue and the output valid flag, and
// loads the default polynomials. The configuration port is always ready; the
// user must write it only while the block is idle; it is not enforced.
module punctured_conv_encoder_k7_unit
  import pcek7_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input channel.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [0:0]             in_tuser,    // [0] op
  input  logic [7:0]             in_tdata,    // [7:0] data_byte
  // Result channel.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,   // [7:0] out_byte, [11:8] valid_bits
  output logic                   out_tlast,   // out_last
  // Configuration write channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [0:0]             cfg_index,
  input  logic [POLY_W-1:0]      cfg_data
);

  logic [POLY_W-1:0] poly_a_r;
  logic [POLY_W-1:0] poly_b_r;
  logic              push;
  logic              pop;
  entry_t            push_entry;
  entry_t            head;
  q_status_t         q_status;

  assign cfg_ready = 1'b1;

  // Polynomial registers; a change applies from the next coded bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_a_r <= POLY_A_RESET;
      poly_b_r <= POLY_B_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index[0]))
        CFG_POLY_A: poly_a_r <= cfg_data;
        CFG_POLY_B: poly_b_r <= cfg_data;
        default:    poly_a_r <= poly_a_r;
      endcase
    end
  end

  // The front end codes a whole byte per word and pushes finished bursts.
  pcek7_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .poly_a     (poly_a_r),
    .poly_b     (poly_b_r),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  // The queue lets the two ends stall independently.
  pcek7_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  // The back end serializes each burst into result words.
  pcek7_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[hw/rtl/pcek7_front.sv]
// Front end of the encoder: accepts input words, runs the convolutional code
// over a whole byte and builds the result bursts. Depends on pcek7_pkg.
module pcek7_front
  import pcek7_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [0:0]         in_tuser,   // [0] op
  input  logic [7:0]         in_tdata,   // [7:0] data_byte
  input  logic [POLY_W-1:0]  poly_a,
  input  logic [POLY_W-1:0]  poly_b,
  input  q_status_t          q_status,
  output logic               push,
  output entry_t             push_entry
);

  logic [SHIFT_W-1:0] shift_r, shift_nxt;
  logic [CODED_W-1:0] pending_r, pending_nxt;
  logic               odd_r, odd_nxt;

  logic               accept;
  logic               is_flush;
  logic [7:0]         data_eff;
  logic [13:0]        hist;       // bit history, oldest in bit 0
  logic [7:0]         par_a;
  logic [7:0]         par_b;
  logic [CODED_W-1:0] coded;
  logic [TAIL_W-1:0]  tail;
  logic [20:0]        tail_odd;

  assign in_tready = !q_status.full;
  assign accept    = in_tvalid && in_tready;
  assign is_flush  = (op_t'(in_tuser[0]) == OP_FLUSH);
  assign data_eff  = is_flush ? 8'h00 : in_tdata;

  // Each step sees a seven-bit window of the history; the windows are
  // independent, so all eight parities are formed side by side.
  always_comb begin
    hist[SHIFT_W-1:0] = shift_r;
    for (int m = 0; m < 8; m++) begin
      hist[SHIFT_W+m] = data_eff[7-m];
    end
    for (int i = 0; i < 8; i++) begin
      par_a[i] = ^(hist[i +: POLY_W] & poly_a);
      par_b[i] = ^(hist[i +: POLY_W] & poly_b);
    end
    for (int p = 0; p < 4; p++) begin
      coded[11-3*p] = par_a[2*p];
      coded[10-3*p] = par_b[2*p];
      coded[9-3*p]  = par_b[2*p+1];
    end
  end

  assign tail     = coded[CODED_W-1:CODED_W-TAIL_W];
  assign tail_odd = {pending_r, tail};

  always_comb begin
    push        = 1'b0;
    push_entry  = '0;
    shift_nxt   = shift_r;
    pending_nxt = pending_r;
    odd_nxt     = odd_r;
    if (accept) begin
      if (is_flush) begin
        push        = 1'b1;
        shift_nxt   = '0;
        pending_nxt = '0;
        odd_nxt     = 1'b0;
        push_entry.last = 1'b1;
        if (odd_r) begin
          push_entry.bytes      = {tail_odd[20:13], tail_odd[12:5], 3'b000, tail_odd[4:0]};
          push_entry.n_bytes    = NBYTES_THREE;
          push_entry.last_vbits = VBITS_TAIL_ODD;
        end else begin
          push_entry.bytes      = {tail[8:1], 7'b0000000, tail[0], 8'h00};
          push_entry.n_bytes    = NBYTES_TWO;
          push_entry.last_vbits = VBITS_TAIL_EVEN;
        end
      end else begin
        shift_nxt = hist[13:8];
        if (odd_r) begin
          push                  = 1'b1;
          push_entry.bytes      = {pending_r, coded};
          push_entry.n_bytes    = NBYTES_THREE;
          push_entry.last       = 1'b0;
          push_entry.last_vbits = VBITS_FULL;
          pending_nxt           = '0;
          odd_nxt               = 1'b0;
        end else begin
          pending_nxt = coded;
          odd_nxt     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r   <= '0;
      pending_r <= '0;
      odd_r     <= 1'b0;
    end else begin
      shift_r   <= shift_nxt;
      pending_r <= pending_nxt;
      odd_r     <= odd_nxt;
    end
  end

endmodule

[hw/rtl/pcek7_queue.sv]
// Short queue of result bursts between the front and back ends.
// Depends on pcek7_pkg for the entry and status types.
module pcek7_queue
  import pcek7_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  entry_t    push_entry,
  input  logic      pop,
  output entry_t    head,
  output q_status_t status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t           slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);
  assign head         = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> !status.full)
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("queue read while empty");
`endif

endmodule

[hw/rtl/pcek7_back.sv]
// Back end of the encoder: splits queued bursts into result words and holds
// them in the output register until taken. Depends on pcek7_pkg.
module pcek7_back
  import pcek7_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  entry_t                 head,
  input  q_status_t              q_status,
  output logic                   pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,   // [7:0] out_byte, [11:8] valid_bits
  output logic                   out_tlast
);

  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             byte_r;
  logic [VBITS_W-1:0]     vbits_r;
  logic                   last_r;
  logic [1:0]             idx_r, idx_nxt;
  logic                   load;
  logic                   final_byte;
  logic [7:0]             sel_byte;

  assign load       = !q_status.empty && (!out_valid_r || out_tready);
  assign final_byte = (idx_r == head.n_bytes - 2'd1);

  always_comb begin
    case (idx_r)
      2'd0:    sel_byte = head.bytes[23:16];
      2'd1:    sel_byte = head.bytes[15:8];
      default: sel_byte = head.bytes[7:0];
    endcase
  end

  assign pop = load && final_byte;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = final_byte ? 2'd0 : idx_r + 2'd1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r  <= sel_byte;
      last_r  <= final_byte && head.last;
      vbits_r <= (final_byte && head.last) ? head.last_vbits : VBITS_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, vbits_r, byte_r};
  assign out_tlast  = last_r;

`ifndef ASSERT_OFF
  a_last_partial: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> (vbits_r == VBITS_TAIL_ODD || vbits_r == VBITS_TAIL_EVEN))
    else $error("final word without a partial byte");

  a_mid_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> (vbits_r == VBITS_FULL))
    else $error("partial byte before the end of a message");
`endif

endmodule

[test/pcek7_stream_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the punctured K=7 convolutional encoder unit.
// It keeps its own encoder model and compares every result word with it.
// Depends on pcek7_pkg.
module pcek7_stream_checker
  import pcek7_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [0:0]             in_tuser,
  input  logic [7:0]             in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tlast,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [0:0]             cfg_index,
  input  logic [POLY_W-1:0]      cfg_data,
  output int                     mismatches,
  output int                     backlog
);

  typedef struct packed {
    logic [7:0]         code_byte;
    logic [VBITS_W-1:0] vbits;
    logic               last;
  } coded_word_t;

  coded_word_t       coded_words_due[$];
  logic [POLY_W-1:0]  poly_a_q;
  logic [POLY_W-1:0]  poly_b_q;
  logic [SHIFT_W-1:0] shift_q;
  logic [CODED_W-1:0] held_bits;
  logic               held_valid;

  // Codes one bit pair: returns the new shift register above the three coded bits.
  function automatic logic [SHIFT_W+2:0] code_pair(logic [SHIFT_W-1:0] sr, logic b1, logic b2);
    logic [POLY_W-1:0]  taps;
    logic [SHIFT_W-1:0] s;
    logic [2:0]         c;
    taps = {b1, sr};
    c[2] = ^(taps & poly_a_q);
    c[1] = ^(taps & poly_b_q);
    s = {b1, sr[SHIFT_W-1:1]};
    taps = {b2, s};
    c[0] = ^(taps & poly_b_q);
    s = {b2, s[SHIFT_W-1:1]};
    return {s, c};
  endfunction

  task automatic queue_word(logic [7:0] b, logic [VBITS_W-1:0] v, logic l);
    coded_word_t w;
    w.code_byte = b;
    w.vbits     = v;
    w.last      = l;
    coded_words_due.insert(coded_words_due.size(), w);
  endtask

  task automatic encode_word(op_t op, logic [7:0] data);
    logic [SHIFT_W+2:0] step;
    logic [CODED_W-1:0] coded;
    logic [23:0]        pair_bits;
    logic [20:0]        tail_bits;
    coded = '0;
    if (op == OP_ENCODE) begin
      for (int j = 7; j > 0; j -= 2) begin
        step    = code_pair(shift_q, data[j], data[j-1]);
        shift_q = step[SHIFT_W+2:3];
        coded   = {coded[CODED_W-4:0], step[2:0]};
      end
      if (!held_valid) begin
        held_bits  = coded;
        held_valid = 1'b1;
      end else begin
        pair_bits = {held_bits, coded};
        queue_word(pair_bits[23:16], VBITS_FULL, 1'b0);
        queue_word(pair_bits[15:8], VBITS_FULL, 1'b0);
        queue_word(pair_bits[7:0], VBITS_FULL, 1'b0);
        held_bits  = '0;
        held_valid = 1'b0;
      end
    end else begin
      // The tail is six zero bits, i.e. three zero pairs.
      repeat (3) begin
        step    = code_pair(shift_q, 1'b0, 1'b0);
        shift_q = step[SHIFT_W+2:3];
        coded   = {coded[CODED_W-4:0], step[2:0]};
      end
      if (held_valid) begin
        tail_bits = {held_bits, coded[TAIL_W-1:0]};
        queue_word(tail_bits[20:13], VBITS_FULL, 1'b0);
        queue_word(tail_bits[12:5], VBITS_FULL, 1'b0);
        queue_word({3'b000, tail_bits[4:0]}, VBITS_TAIL_ODD, 1'b1);
      end else begin
        queue_word(coded[8:1], VBITS_FULL, 1'b0);
        queue_word({7'b0000000, coded[0]}, VBITS_TAIL_EVEN, 1'b1);
      end
      shift_q    = '0;
      held_bits  = '0;
      held_valid = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    coded_word_t want;
    if (!rst_n) begin
      poly_a_q   = POLY_A_RESET;
      poly_b_q   = POLY_B_RESET;
      shift_q    = '0;
      held_bits  = '0;
      held_valid = 1'b0;
      mismatches = 0;
      coded_words_due.delete();
    end else begin
      // Results are checked before this edge's input is modeled, since a word
      // can never come out on the edge that accepts its cause.
      if (out_tvalid && out_tready) begin
        if (coded_words_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word, actual byte=%h vbits=%0d last=%b",
                   $time, out_tdata[7:0], out_tdata[11:8], out_tlast);
        end else begin
          want = coded_words_due.pop_front();
          if (out_tdata[7:0] !== want.code_byte || out_tdata[11:8] !== want.vbits ||
              out_tlast !== want.last) begin
            mismatches++;
            $display("%0t: mismatch, expected byte=%h vbits=%0d last=%b, %s%h vbits=%0d last=%b",
                     $time, want.code_byte, want.vbits, want.last, "actual byte=",
                     out_tdata[7:0], out_tdata[11:8], out_tlast);
          end
        end
      end
      // An input word on this edge is coded with the polynomials held before it.
      if (in_tvalid && in_tready) begin
        encode_word(op_t'(in_tuser[0]), in_tdata);
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_idx_t'(cfg_index[0]) == CFG_POLY_A) begin
          poly_a_q = cfg_data;
        end else begin
          poly_b_q = cfg_data;
        end
      end
    end
    backlog = coded_words_due.size();
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// Top of the testbench for punctured_conv_encoder_k7_unit.
// Drives words and polynomial writes with random idling; the checking is done
// by pcek7_stream_checker. Depends on pcek7_pkg and the checker.
module testbench;
  import pcek7_pkg::*;

  // Cycles allowed after the last expected word for a word that causes no
  // result to finish inside the block.
  localparam int SETTLE_CYCLES = 6;
  localparam int TARGET_WORDS  = 470;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [0:0]             in_tuser = 1'b0;
  logic [7:0]             in_tdata = 8'h00;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [0:0]             cfg_index = 1'b0;
  logic [POLY_W-1:0]      cfg_data = '0;

  int mismatches;
  int backlog;
  int words_sent = 0;
  // When set, neither side idles, giving stretches at full rate.
  bit quiet = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  punctured_conv_encoder_k7_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  pcek7_stream_checker scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .backlog    (backlog)
  );

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Polynomials: the range ends often, and zero now and then.
  function automatic logic [POLY_W-1:0] pick_poly();
    int r;
    r = $urandom_range(0, 11);
    if (r == 0) return '0;
    if (r == 1) return 7'd1;
    if (r == 2) return 7'd127;
    return 7'($urandom_range(1, 127));
  endfunction

  // Receiver: runs of ready broken by stalls of random length.
  initial begin
    forever begin
      repeat ($urandom_range(1, 12)) begin
        @(posedge clk);
        out_tready <= 1'b1;
      end
      repeat (idle_len()) begin
        @(posedge clk);
        out_tready <= 1'b0;
      end
    end
  end

  // Sends one word. Called at a rising edge; returns at the edge that accepted
  // it. Ready is looked at on the falling edge, where every input is settled.
  task automatic put_word(op_t op, logic [7:0] b);
    int gap;
    bit ready_seen;
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= b;
    do begin
      @(negedge clk);
      ready_seen = in_tready;
      @(posedge clk);
    end while (!ready_seen);
    words_sent++;
  endtask

  // Holds the sender off until every expected word is out, then lets the
  // block settle so that a pending half pair is fully absorbed.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (backlog != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both polynomials back to back; valid stays high between them.
  task automatic write_polys(logic [POLY_W-1:0] pa, logic [POLY_W-1:0] pb);
    bit ready_seen;
    for (int i = 0; i < 2; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (i == 0) ? CFG_POLY_A : CFG_POLY_B;
      cfg_data  <= (i == 0) ? pa : pb;
      do begin
        @(negedge clk);
        ready_seen = cfg_ready;
        @(posedge clk);
      end while (!ready_seen);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int len;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty message: a flush straight after reset gives the bare tail.
    put_word(OP_FLUSH, 8'h00);
    // Field extremes in an even message; the flush carries a data byte that
    // must be ignored.
    put_word(OP_ENCODE, 8'h00);
    put_word(OP_ENCODE, 8'hFF);
    put_word(OP_FLUSH, 8'hFF);
    // Odd message, so the flush carries a held byte.
    put_word(OP_ENCODE, 8'h80);
    put_word(OP_ENCODE, 8'h01);
    put_word(OP_ENCODE, 8'hAA);
    put_word(OP_FLUSH, 8'h5A);

    // Polynomials changed in the middle of a message, with a byte held.
    put_word(OP_ENCODE, 8'h3C);
    drain();
    write_polys(7'd127, 7'd1);
    put_word(OP_ENCODE, 8'hC3);
    put_word(OP_FLUSH, 8'hA5);
    drain();

    // Zero polynomials give all-zero parities on their side.
    write_polys(7'd0, 7'd127);
    put_word(OP_ENCODE, 8'hFF);
    put_word(OP_ENCODE, 8'h7E);
    put_word(OP_ENCODE, 8'h81);
    put_word(OP_FLUSH, 8'h00);
    drain();
    write_polys(7'd1, 7'd0);
    put_word(OP_ENCODE, 8'h5A);
    put_word(OP_ENCODE, 8'h55);
    put_word(OP_FLUSH, 8'h00);
    drain();
    write_polys(POLY_A_RESET, POLY_B_RESET);

    // Random messages of random content, under changing polynomials.
    while (words_sent < TARGET_WORDS) begin
      if ($urandom_range(0, 3) == 0) begin
        drain();
        write_polys(pick_poly(), pick_poly());
      end else if ($urandom_range(0, 5) == 0) begin
        drain();
      end
      quiet = ($urandom_range(0, 4) == 0);
      len = $urandom_range(0, 99);
      if (len < 10) len = 0;
      else if (len < 85) len = $urandom_range(1, 8);
      else len = $urandom_range(9, 20);
      for (int i = 0; i < len; i++) begin
        put_word(OP_ENCODE, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 19) == 0) begin
          drain();
          write_polys(pick_poly(), pick_poly());
        end
      end
      put_word(OP_FLUSH, 8'($urandom_range(0, 255)));
    end

    in_tvalid <= 1'b0;
    quiet = 1'b0;
    do @(negedge clk); while (backlog != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && backlog == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/pcek7_pkg.sv
hw/rtl/pcek7_front.sv
hw/rtl/pcek7_queue.sv
hw/rtl/pcek7_back.sv
hw/rtl/punctured_conv_encoder_k7_unit.sv
test/pcek7_stream_checker.sv
test/testbench.sv
